// File: rtl/core/smm_pkg.sv
`timescale 1ns / 1ps

package smm_pkg;

   localparam int MAX_ANTENNAS = 8;
   localparam int MAX_ACTIVE   = 4;
   localparam int TABLE_DEPTH  = 64;
   localparam int SAMPLE_WIDTH = 16;

   localparam int BLOCK_BITS  = 22;
   localparam int ANT_W       = 3;
   localparam int LIST_W      = 12;
   localparam int INDEX_W     = 6;
   localparam int CODE_W      = 4;
   localparam int LEAD_W      = 7;
   localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 4;

   localparam logic [1:0] MOD_BPSK  = 2'd0;
   localparam logic [1:0] MOD_QPSK  = 2'd1;
   localparam logic [1:0] MOD_QAM16 = 2'd2;
   localparam logic [1:0] MOD_OFF   = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] REG_SELECT_BITS   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_MODULATION    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_ANTENNA_COUNT = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_ACTIVE_COUNT  = 2'd3;

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;
   typedef logic [CODE_W-1:0] code_type;

   typedef struct packed {
      logic [2:0] select_bits;
      logic [1:0] modulation;
      logic [3:0] antenna_count;
      logic [2:0] active_count;
   } cfg_type;

   // levels held with 30 fraction bits, rounded half up
   localparam int LVL_SHIFT = 30 - (SAMPLE_WIDTH - 2);
   localparam longint LVL_HALF = longint'(1) << (LVL_SHIFT - 1);
   localparam sample_type LVL_ONE =
      SAMPLE_WIDTH'((longint'(1073741824) + LVL_HALF) >> LVL_SHIFT);
   localparam sample_type LVL_RSQ2 =
      SAMPLE_WIDTH'((longint'(759250125) + LVL_HALF) >> LVL_SHIFT);
   localparam sample_type LVL_RSQ10 =
      SAMPLE_WIDTH'((longint'(339546978) + LVL_HALF) >> LVL_SHIFT);
   localparam sample_type LVL_3RSQ10 =
      SAMPLE_WIDTH'((longint'(1018640935) + LVL_HALF) >> LVL_SHIFT);

   // selector wraps onto the table depth, restoring remainder
   function automatic logic [ADDR_W-1:0] wrap_index(input logic [LEAD_W-1:0] raw);
      logic [13:0] rem;
      rem = {7'd0, raw};
      for (int k = LEAD_W - 1; k >= 0; k--) begin
         if (rem >= 14'(TABLE_DEPTH << k)) begin
            rem = rem - 14'(TABLE_DEPTH << k);
         end
      end
      return rem[ADDR_W-1:0];
   endfunction

endpackage

// File: rtl/core/smm_req_if.sv
`timescale 1ns / 1ps

interface smm_req_if import smm_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      func;
   logic [INDEX_W-1:0]        table_index;
   logic [LIST_W-1:0]         antenna_list;
   logic [BLOCK_BITS-1:0]     bit_block;

   modport source (output valid, output func, output table_index, output antenna_list,
                   output bit_block, input ready);
   modport sink (input valid, input func, input table_index, input antenna_list,
                 input bit_block, output ready);
endinterface

// File: rtl/core/smm_rsp_if.sv
`timescale 1ns / 1ps

interface smm_rsp_if import smm_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [ANT_W-1:0] antenna;
   sample_type       real_part;
   sample_type       imag_part;
   logic             last;

   modport source (output valid, output antenna, output real_part, output imag_part,
                   output last, input ready);
   modport sink (input valid, input antenna, input real_part, input imag_part,
                 input last, output ready);
endinterface

// File: rtl/core/smm_csr.sv
`timescale 1ns / 1ps

module smm_csr import smm_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   output cfg_type                cfg
);

   logic [2:0] select_bits_ff;
   logic [1:0] modulation_ff;
   logic [3:0] antenna_count_ff;
   logic [2:0] active_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         select_bits_ff   <= 3'd2;
         modulation_ff    <= MOD_QPSK;
         antenna_count_ff <= 4'd4;
         active_count_ff  <= 3'd2;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_SELECT_BITS:   select_bits_ff   <= csr_write_data[2:0];
            REG_MODULATION:    modulation_ff    <= csr_write_data[1:0];
            REG_ANTENNA_COUNT: antenna_count_ff <= csr_write_data[3:0];
            REG_ACTIVE_COUNT:  active_count_ff  <= csr_write_data[2:0];
            default: ;
         endcase
      end
   end

   // counts capped at the build limits
   always_comb begin
      cfg.select_bits   = select_bits_ff;
      cfg.modulation    = modulation_ff;
      cfg.antenna_count = (int'(antenna_count_ff) > MAX_ANTENNAS) ?
                          4'(MAX_ANTENNAS) : antenna_count_ff;
      cfg.active_count  = (int'(active_count_ff) > MAX_ACTIVE) ?
                          3'(MAX_ACTIVE) : active_count_ff;
   end

endmodule

// File: rtl/core/smm_front.sv
`timescale 1ns / 1ps

module smm_front import smm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   smm_req_if.sink           req,
   input  logic              s1_ready,
   output logic              s1_valid,
   output code_type          s1_code [MAX_ACTIVE],
   output logic [LIST_W-1:0] s1_entry
);

   logic [LIST_W-1:0] comb_mem [TABLE_DEPTH];
   logic              s1_valid_ff;
   logic              s1_valid_in;
   code_type          code_ff [MAX_ACTIVE];
   code_type          code_in [MAX_ACTIVE];
   logic [LIST_W-1:0] entry_ff;
   logic              fire;
   logic              load_en;
   logic              enc_en;
   logic [LEAD_W-1:0] lead;
   logic [LEAD_W-1:0] sel_raw;
   logic [ADDR_W-1:0] rd_addr;
   logic [2:0]        bps;
   logic [4:0]        first;
   logic [BLOCK_BITS-1:0] shifted;
   logic [CODE_W-1:0] nib;

   assign req.ready = !s1_valid_ff || s1_ready;
   assign fire      = req.valid && req.ready;
   assign load_en   = fire && !req.func && (int'(req.table_index) < TABLE_DEPTH);
   assign enc_en    = fire && req.func;
   assign s1_valid_in = enc_en;

   // earliest bit most significant
   always_comb begin
      for (int k = 0; k < LEAD_W; k++) begin
         lead[LEAD_W-1-k] = req.bit_block[k];
      end
      sel_raw = lead >> (3'd7 - cfg.select_bits);
      rd_addr = wrap_index(sel_raw);
   end

   always_comb begin
      unique case (cfg.modulation)
         MOD_BPSK: bps = 3'd1;
         MOD_QPSK: bps = 3'd2;
         default:  bps = 3'd4;
      endcase
      first   = '0;
      shifted = '0;
      nib     = '0;
      for (int i = 0; i < MAX_ACTIVE; i++) begin
         first   = 5'(cfg.select_bits) + 5'(int'(bps) * i);
         shifted = req.bit_block >> first;
         nib     = shifted[CODE_W-1:0];
         code_in[i] = CODE_W'({nib[0], nib[1], nib[2], nib[3]} >> (3'd4 - bps));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req.ready) begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_en) begin
         comb_mem[req.table_index[ADDR_W-1:0]] <= req.antenna_list;
      end
      if (enc_en) begin
         entry_ff <= comb_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (enc_en) begin
         code_ff <= code_in;
      end
   end

   assign s1_valid = s1_valid_ff;
   assign s1_code  = code_ff;
   assign s1_entry = entry_ff;

endmodule

// File: rtl/core/smm_map.sv
`timescale 1ns / 1ps

module smm_map import smm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              s1_valid,
   input  code_type          s1_code [MAX_ACTIVE],
   input  logic [LIST_W-1:0] s1_entry,
   output logic              s1_ready,
   input  logic              s3_take,
   output logic              s2_valid,
   output sample_type        s2_re [MAX_ANTENNAS],
   output sample_type        s2_im [MAX_ANTENNAS]
);

   typedef struct packed {
      sample_type re;
      sample_type im;
   } point_type;

   function automatic sample_type qam_level(input logic [1:0] n);
      sample_type mag;
      mag = n[0] ? LVL_RSQ10 : LVL_3RSQ10;
      return n[1] ? mag : -mag;
   endfunction

   function automatic point_type map_point(input logic [1:0] mode, input code_type n);
      point_type p;
      p.re = '0;
      p.im = '0;
      unique case (mode)
         MOD_BPSK: begin
            p.re = n[0] ? LVL_ONE : -LVL_ONE;
         end
         MOD_QPSK: begin
            p.re = n[1] ? LVL_RSQ2 : -LVL_RSQ2;
            p.im = n[0] ? LVL_RSQ2 : -LVL_RSQ2;
         end
         MOD_QAM16: begin
            p.re = qam_level(n[3:2]);
            p.im = qam_level(n[1:0]);
         end
         default: ;
      endcase
      return p;
   endfunction

   logic       s2_valid_ff;
   sample_type re_ff [MAX_ANTENNAS];
   sample_type im_ff [MAX_ANTENNAS];
   sample_type re_in [MAX_ANTENNAS];
   sample_type im_in [MAX_ANTENNAS];
   point_type  pt [MAX_ACTIVE];
   logic [ANT_W-1:0] ant [MAX_ACTIVE];

   assign s1_ready = !s2_valid_ff || s3_take;

   always_comb begin
      for (int i = 0; i < MAX_ACTIVE; i++) begin
         pt[i]  = map_point(cfg.modulation, s1_code[i]);
         ant[i] = s1_entry[ANT_W*i +: ANT_W];
      end
   end

   // later slot wins on a repeated antenna
   always_comb begin
      for (int a = 0; a < MAX_ANTENNAS; a++) begin
         re_in[a] = '0;
         im_in[a] = '0;
         for (int i = 0; i < MAX_ACTIVE; i++) begin
            if (i < int'(cfg.active_count) && int'(ant[i]) == a
                && a < int'(cfg.antenna_count)) begin
               re_in[a] = pt[i].re;
               im_in[a] = pt[i].im;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s2_valid_ff <= s1_valid && (cfg.antenna_count != 4'd0);
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && s1_valid) begin
         re_ff <= re_in;
         im_ff <= im_in;
      end
   end

   assign s2_valid = s2_valid_ff;
   assign s2_re    = re_ff;
   assign s2_im    = im_ff;

endmodule

// File: rtl/core/smm_serial.sv
`timescale 1ns / 1ps

module smm_serial import smm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       s2_valid,
   input  sample_type s2_re [MAX_ANTENNAS],
   input  sample_type s2_im [MAX_ANTENNAS],
   output logic       s3_take,
   smm_rsp_if.source  rsp
);

   logic             s3_valid_ff;
   logic [ANT_W-1:0] idx_ff;
   sample_type       re_ff [MAX_ANTENNAS];
   sample_type       im_ff [MAX_ANTENNAS];
   logic             last;
   logic             beat;

   assign last    = (4'(idx_ff) + 4'd1) == cfg.antenna_count;
   assign beat    = s3_valid_ff && rsp.ready;
   assign s3_take = !s3_valid_ff || (rsp.ready && last);

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         idx_ff      <= '0;
      end else if (s3_take) begin
         s3_valid_ff <= s2_valid;
         idx_ff      <= '0;
      end else if (beat) begin
         idx_ff <= idx_ff + 3'd1;
      end
   end

   // results leave from the bottom of a shift line
   always_ff @(posedge clock) begin
      if (s3_take && s2_valid) begin
         re_ff <= s2_re;
         im_ff <= s2_im;
      end else if (beat) begin
         for (int a = 0; a < MAX_ANTENNAS - 1; a++) begin
            re_ff[a] <= re_ff[a+1];
            im_ff[a] <= im_ff[a+1];
         end
      end
   end

   assign rsp.valid     = s3_valid_ff;
   assign rsp.antenna   = idx_ff;
   assign rsp.real_part = re_ff[0];
   assign rsp.imag_part = im_ff[0];
   assign rsp.last      = last;

`ifndef NO_ASSERTIONS
   a_step_on_beat : assert property (@(posedge clock) disable iff (reset)
      (beat && !last) |=> (s3_valid_ff && idx_ff == $past(idx_ff) + 3'd1))
      else $error("antenna index did not step after a beat");

   a_hold_on_stall : assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && !rsp.ready) |=> (s3_valid_ff && $stable(idx_ff) && $stable(re_ff[0])))
      else $error("serialiser state moved while stalled");

   a_drain_empty : assert property (@(posedge clock) disable iff (reset)
      (s3_take && !s2_valid) |=> !s3_valid_ff)
      else $error("serialiser busy with nothing loaded");
`endif

endmodule

// File: rtl/core/spatial_modulation_mapper.sv
`timescale 1ns / 1ps

// Spatial modulation mapper. A load beat (func 0) writes one antenna combination entry and
// gives no result; an encode beat (func 1) gives one result per transmit antenna, antenna 0
// first, with last on the final one. Input beats are taken every cycle while the pipeline has
// room: table read and bit slicing, constellation mapping and antenna scatter, then an output
// shift line. rsp valid rises once an encode item has passed the slicing, mapping and shift
// line valid registers; the shift line sends one result per cycle while rsp ready is high,
// so an encode item gives antenna_count results (up to 8, none when the count is zero) and
// the next item enters only as the last result leaves. The combination table has no reset;
// the user must write registers only with no item in flight; the block does not enforce it.

module spatial_modulation_mapper import smm_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   smm_req_if.sink                req_if,
   smm_rsp_if.source              rsp_if,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   cfg_type           cfg;
   logic              s1_valid;
   logic              s1_ready;
   code_type          s1_code [MAX_ACTIVE];
   logic [LIST_W-1:0] s1_entry;
   logic              s2_valid;
   logic              s3_take;
   sample_type        s2_re [MAX_ANTENNAS];
   sample_type        s2_im [MAX_ANTENNAS];

   smm_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   smm_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req      (req_if),
      .s1_ready (s1_ready),
      .s1_valid (s1_valid),
      .s1_code  (s1_code),
      .s1_entry (s1_entry)
   );

   smm_map u_map (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .s1_valid (s1_valid),
      .s1_code  (s1_code),
      .s1_entry (s1_entry),
      .s1_ready (s1_ready),
      .s3_take  (s3_take),
      .s2_valid (s2_valid),
      .s2_re    (s2_re),
      .s2_im    (s2_im)
   );

   smm_serial u_serial (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .s2_valid (s2_valid),
      .s2_re    (s2_re),
      .s2_im    (s2_im),
      .s3_take  (s3_take),
      .rsp      (rsp_if)
   );

endmodule

// File: test/mapper_checker.sv
`timescale 1ns / 1ps

module mapper_checker import smm_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   smm_req_if                     req_mon,
   smm_rsp_if                     rsp_mon,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   output int                     fail_count,
   output int                     pending,
   output int                     checked
);

   localparam int     FRAC_SHIFT = 30 - (SAMPLE_WIDTH - 2);
   localparam longint ROUND_HALF = longint'(1) << (FRAC_SHIFT - 1);

   // q30 levels rounded half up to the sample format
   localparam sample_type LEVEL_UNIT =
      SAMPLE_WIDTH'((longint'(1073741824) + ROUND_HALF) >> FRAC_SHIFT);
   localparam sample_type LEVEL_RSQ2 =
      SAMPLE_WIDTH'((longint'(759250125) + ROUND_HALF) >> FRAC_SHIFT);
   localparam sample_type LEVEL_LOW =
      SAMPLE_WIDTH'((longint'(339546978) + ROUND_HALF) >> FRAC_SHIFT);
   localparam sample_type LEVEL_HIGH =
      SAMPLE_WIDTH'((longint'(1018640935) + ROUND_HALF) >> FRAC_SHIFT);

   typedef struct packed {
      logic [ANT_W-1:0] antenna;
      sample_type       in_phase;
      sample_type       quadrature;
      logic             last;
   } antenna_sample_type;

   antenna_sample_type sample_queue [$];
   logic [LIST_W-1:0]  combo_table [TABLE_DEPTH];
   logic [2:0]         sel_bits_q;
   logic [1:0]         mod_q;
   logic [3:0]         tx_count_q;
   logic [2:0]         act_count_q;
   antenna_sample_type got;
   antenna_sample_type want;

   // bits past the end of the block read as zero
   function automatic int read_bits(input logic [BLOCK_BITS-1:0] blk, input int first,
                                    input int len);
      int value;
      int bit_val;
      value = 0;
      for (int k = 0; k < len; k++) begin
         bit_val = 0;
         if (first + k < BLOCK_BITS) bit_val = int'(blk[first + k]);
         value = (value << 1) | bit_val;
      end
      return value;
   endfunction

   // 16-qam axis order: -3, -1, +3, +1
   function automatic sample_type qam_axis(input int code);
      sample_type mag;
      mag = (code % 2 == 1) ? LEVEL_LOW : LEVEL_HIGH;
      return (code < 2) ? -mag : mag;
   endfunction

   task automatic map_block(input logic [BLOCK_BITS-1:0] blk);
      sample_type         re_v [MAX_ANTENNAS];
      sample_type         im_v [MAX_ANTENNAS];
      int                 n_tx;
      int                 n_act;
      int                 bps;
      int                 sel;
      int                 code;
      int                 ant;
      sample_type         r;
      sample_type         q;
      logic [LIST_W-1:0]  entry;
      antenna_sample_type s;
      n_tx  = (tx_count_q > MAX_ANTENNAS) ? MAX_ANTENNAS : int'(tx_count_q);
      n_act = (act_count_q > MAX_ACTIVE) ? MAX_ACTIVE : int'(act_count_q);
      for (int a = 0; a < MAX_ANTENNAS; a++) begin
         re_v[a] = '0;
         im_v[a] = '0;
      end
      if (mod_q != MOD_OFF) begin
         case (mod_q)
            MOD_BPSK: bps = 1;
            MOD_QPSK: bps = 2;
            default:  bps = 4;
         endcase
         sel   = read_bits(blk, 0, int'(sel_bits_q)) % TABLE_DEPTH;
         entry = combo_table[sel];
         for (int i = 0; i < n_act; i++) begin
            ant  = int'(entry[3*i +: 3]);
            code = read_bits(blk, int'(sel_bits_q) + bps * i, bps);
            case (mod_q)
               MOD_BPSK: begin
                  r = (code == 1) ? LEVEL_UNIT : -LEVEL_UNIT;
                  q = '0;
               end
               MOD_QPSK: begin
                  r = (code >= 2) ? LEVEL_RSQ2 : -LEVEL_RSQ2;
                  q = (code % 2 == 1) ? LEVEL_RSQ2 : -LEVEL_RSQ2;
               end
               default: begin
                  r = qam_axis(code >> 2);
                  q = qam_axis(code % 4);
               end
            endcase
            if (ant < n_tx) begin
               re_v[ant] = r;
               im_v[ant] = q;
            end
         end
      end
      for (int a = 0; a < n_tx; a++) begin
         s.antenna    = ANT_W'(a);
         s.in_phase   = re_v[a];
         s.quadrature = im_v[a];
         s.last       = (a == n_tx - 1);
         sample_queue = {sample_queue, s};
      end
   endtask

   task automatic compare_field(input string what, input logic signed [31:0] expected,
                                input logic signed [31:0] actual);
      if (actual !== expected) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, expected, actual);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         sel_bits_q  = 3'd2;
         mod_q       = MOD_QPSK;
         tx_count_q  = 4'd4;
         act_count_q = 3'd2;
         sample_queue.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               REG_SELECT_BITS:   sel_bits_q  = csr_write_data[2:0];
               REG_MODULATION:    mod_q       = csr_write_data[1:0];
               REG_ANTENNA_COUNT: tx_count_q  = csr_write_data[3:0];
               REG_ACTIVE_COUNT:  act_count_q = csr_write_data[2:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.func) begin
               map_block(req_mon.bit_block);
            end else begin
               combo_table[req_mon.table_index] = req_mon.antenna_list;
            end
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.antenna    = rsp_mon.antenna;
            got.in_phase   = rsp_mon.real_part;
            got.quadrature = rsp_mon.imag_part;
            got.last       = rsp_mon.last;
            checked++;
            if (sample_queue.size() == 0) begin
               $display("%0t: result beat with nothing expected, expected none, %s",
                        $time, "got the following beat");
               $display("   antenna %0d re %0d im %0d last %0b",
                        got.antenna, got.in_phase, got.quadrature, got.last);
               fail_count++;
            end else begin
               want = sample_queue.pop_front();
               compare_field("antenna", {29'd0, want.antenna}, {29'd0, got.antenna});
               compare_field("real part", want.in_phase, got.in_phase);
               compare_field("imag part", want.quadrature, got.quadrature);
               compare_field("last", {31'd0, want.last}, {31'd0, got.last});
            end
         end
      end
      pending = sample_queue.size();
   end

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps

module testbench import smm_pkg::*; ();

   localparam int PERIOD         = 10;
   localparam int RESET_CYCLES   = 7;
   localparam int DRAIN_PAD      = 16;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_PHASES  = 12;
   localparam int PHASE_ITEMS    = 37;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   int fail_count;
   int pending;
   int checked;

   smm_req_if req_bus ();
   smm_rsp_if rsp_bus ();

   spatial_modulation_mapper u_top (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_bus),
      .rsp_if           (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   mapper_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_bus),
      .rsp_mon          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .pending          (pending),
      .checked          (checked)
   );

   always #(PERIOD / 2) clock = ~clock;

   bit         written [TABLE_DEPTH];
   bit         quiet_phase;
   int         gap_chance;
   int         cur_select;
   int         cur_tx;
   int         ready_left;
   int         idle_cycles;
   int         load_beats;
   int         encode_beats;
   int         settings_used;

   // receiver stalls in bursts, long clear runs now and then
   always @(posedge clock) begin
      if (quiet_phase) begin
         rsp_bus.ready <= 1'b1;
         ready_left    <= 0;
      end else if (ready_left != 0) begin
         ready_left <= ready_left - 1;
      end else if (rsp_bus.ready && $urandom_range(0, 2) == 0) begin
         rsp_bus.ready <= 1'b0;
         ready_left    <= $urandom_range(0, 16);
      end else begin
         rsp_bus.ready <= 1'b1;
         ready_left    <= ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                       : $urandom_range(0, 12);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no beat for %0d cycles, %0d results outstanding",
                  $time, idle_cycles, pending);
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_beat(input logic f, input logic [INDEX_W-1:0] idx,
                            input logic [LIST_W-1:0] lst, input logic [BLOCK_BITS-1:0] blk);
      if (!quiet_phase && $urandom_range(1, 100) <= gap_chance) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.func         <= f;
      req_bus.table_index  <= idx;
      req_bus.antenna_list <= lst;
      req_bus.bit_block    <= blk;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      if (f) begin
         encode_beats++;
      end else begin
         written[idx] = 1'b1;
         load_beats++;
      end
   endtask

   // steer the leading bits onto a combination entry that has been loaded
   function automatic logic [BLOCK_BITS-1:0] aim_selector(input logic [BLOCK_BITS-1:0] blk);
      logic [BLOCK_BITS-1:0] aimed;
      logic [6:0]            lead;
      int                    span;
      int                    want;
      aimed = blk;
      lead  = '0;
      for (int i = 0; i < cur_select; i++) lead = {lead[5:0], blk[i]};
      if (written[lead % TABLE_DEPTH]) return blk;
      span = (cur_select >= 6) ? TABLE_DEPTH : (1 << cur_select);
      do want = $urandom_range(0, span - 1); while (!written[want]);
      lead = 7'(want);
      if (cur_select == 7 && $urandom_range(0, 1) == 1) lead[6] = 1'b1;
      for (int i = 0; i < cur_select; i++) aimed[i] = lead[cur_select - 1 - i];
      return aimed;
   endfunction

   function automatic logic [LIST_W-1:0] random_list();
      logic [LIST_W-1:0] lst;
      int                span;
      lst  = LIST_W'($urandom);
      span = (cur_tx > MAX_ANTENNAS) ? MAX_ANTENNAS : cur_tx;
      if (span > 0 && $urandom_range(0, 3) != 0) begin
         for (int s = 0; s < MAX_ACTIVE; s++) lst[3*s +: 3] = 3'($urandom_range(0, span - 1));
      end
      return lst;
   endfunction

   task automatic write_combo(input logic [INDEX_W-1:0] idx, input logic [LIST_W-1:0] lst);
      send_beat(1'b0, idx, lst, BLOCK_BITS'($urandom));
   endtask

   task automatic send_block(input logic [BLOCK_BITS-1:0] blk);
      send_beat(1'b1, INDEX_W'($urandom), LIST_W'($urandom), aim_selector(blk));
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_PAD) @(posedge clock);
   endtask

   task automatic apply_settings(input int sb, input logic [1:0] mod, input int tx, input int act);
      csr_write_enable <= 1'b1;
      csr_index        <= REG_SELECT_BITS;
      csr_write_data   <= CSR_DATA_W'(sb);
      @(posedge clock);
      csr_index        <= REG_MODULATION;
      csr_write_data   <= CSR_DATA_W'(mod);
      @(posedge clock);
      csr_index        <= REG_ANTENNA_COUNT;
      csr_write_data   <= CSR_DATA_W'(tx);
      @(posedge clock);
      csr_index        <= REG_ACTIVE_COUNT;
      csr_write_data   <= CSR_DATA_W'(act);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cur_select = sb;
      cur_tx     = tx;
      settings_used++;
   endtask

   initial begin
      int         sb;
      int         tx;
      int         act;
      int         pick;
      logic [1:0] mod;
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.func         = 1'b0;
      req_bus.table_index  = '0;
      req_bus.antenna_list = '0;
      req_bus.bit_block    = '0;
      rsp_bus.ready        = 1'b0;
      csr_write_enable     = 1'b0;
      csr_index            = '0;
      csr_write_data       = '0;
      quiet_phase          = 1'b0;
      gap_chance           = 25;
      cur_select           = 2;
      cur_tx               = 4;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed: reset settings, qpsk over four antennas, two active
      write_combo(6'd0, {3'd0, 3'd1, 3'd2, 3'd3});
      write_combo(6'd63, 12'hFFF);
      write_combo(6'd1, {3'd5, 3'd2, 3'd1, 3'd1});
      write_combo(6'd2, 12'h000);
      write_combo(6'd3, {3'd7, 3'd6, 3'd0, 3'd3});
      send_block(22'h000000);
      send_block(22'h3FFFFF);
      send_block(22'h2AAAAA);
      send_block(22'h155555);
      wait_idle();
      apply_settings(6, MOD_BPSK, 8, 4);
      write_combo(6'd63, {3'd4, 3'd5, 3'd6, 3'd7});
      send_block(22'h3FFFFF);
      send_block(22'h000000);
      wait_idle();
      // selector wider than the table, counts beyond their caps, bits past the block
      apply_settings(7, MOD_QAM16, 15, 7);
      send_block(22'h3FFFFF);
      send_block(BLOCK_BITS'($urandom));
      wait_idle();
      apply_settings(6, MOD_OFF, 8, 4);
      send_block(22'h3FFFFF);
      wait_idle();
      apply_settings(0, MOD_QAM16, 0, 4);
      send_block(BLOCK_BITS'($urandom));
      send_block(BLOCK_BITS'($urandom));
      wait_idle();
      apply_settings(0, MOD_QPSK, 1, 1);
      send_block(22'h000000);
      send_block(22'h3FFFFF);
      wait_idle();
      apply_settings(3, MOD_BPSK, 8, 0);
      send_block(BLOCK_BITS'($urandom));
      wait_idle();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p == 0) begin
            sb = 6; mod = MOD_QAM16; tx = 8; act = 4;
         end else if (p == 1) begin
            sb = 0; mod = MOD_BPSK; tx = 1; act = 1;
         end else begin
            sb   = ($urandom_range(0, 9) == 0) ? 7 : $urandom_range(0, 6);
            pick = $urandom_range(0, 9);
            mod  = (pick < 3) ? MOD_BPSK : (pick < 6) ? MOD_QPSK : (pick < 9) ? MOD_QAM16
                                                                          : MOD_OFF;
            tx   = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
            act  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
         end
         quiet_phase = (p == RANDOM_PHASES - 1);
         pick        = $urandom_range(0, 2);
         gap_chance  = (pick == 0) ? 0 : (pick == 1) ? 12 : 35;
         apply_settings(sb, mod, tx, act);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (p == 4 && k == PHASE_ITEMS / 2) wait_idle();
            if ($urandom_range(0, 99) < 15) begin
               write_combo(INDEX_W'($urandom), random_list());
            end else begin
               send_block(BLOCK_BITS'($urandom));
            end
         end
         wait_idle();
      end

      $display("%0d table loads and %0d bit blocks sent across %0d register settings",
               load_beats, encode_beats, settings_used);
      $display("%0d antenna result beats compared, %0d mismatches", checked, fail_count);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
